/* rtl/bddp_pkg.sv */
package bddp_pkg;

  localparam int LimitW  = 7;
  localparam int WindowW = 16;
  localparam int StateW  = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = WindowW;

  localparam logic [LimitW-1:0]  LimitReset  = 7'd10;
  localparam logic [WindowW-1:0] WindowReset = 16'd0;

  localparam logic [CfgIdxW-1:0] RegDebounceLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDoubleWindow  = 1'd1;

  localparam logic [StateW-1:0] ST_WAIT_PUSH        = 3'd0;
  localparam logic [StateW-1:0] ST_WAIT_RELEASE     = 3'd1;
  localparam logic [StateW-1:0] ST_WAIT_DBL_PUSH    = 3'd2;
  localparam logic [StateW-1:0] ST_WAIT_DBL_RELEASE = 3'd3;
  localparam logic [StateW-1:0] ST_DBL_HOLDOFF      = 3'd4;
  localparam logic [StateW-1:0] ST_TIMEOUT          = 3'd5;
  localparam logic [StateW-1:0] ST_PUSH_RESET       = 3'd6;

  typedef struct packed {
    logic filtered;
    logic push;
    logic release_ev;
    logic dbl;
    logic irq;
  } result_t;

endpackage

/* rtl/button_debounce_double_push.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | switch_pressed
// out      | out_valid / out_ready| filtered_pressed, push_event,
//          |                      | release_event, double_push_event, irq_pulse
// cfg      | cfg_write            | cfg_index, cfg_data
//
// One request per clock unless out is stalled: the state update and the
// result are one level of logic between the state and output registers.
// A result appears on out in the cycle after its request is accepted.
// Reset clears the state machine and counters and loads the register defaults
// (limit 10, window 0); no result is pending after reset.
// While out is stalled the output register holds and in_ready is low; a new
// request is taken in the same cycle the pending result is taken.
module button_debounce_double_push (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          switch_pressed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          filtered_pressed,
  output logic                          push_event,
  output logic                          release_event,
  output logic                          double_push_event,
  output logic                          irq_pulse,
  input  logic                          cfg_write,
  input  logic [bddp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bddp_pkg::CfgDataW-1:0] cfg_data
);
  import bddp_pkg::*;

  logic [LimitW-1:0]  limit;
  logic [WindowW-1:0] window;
  logic [StateW-1:0]  state, state_next;
  logic [WindowW-1:0] win_cnt, win_cnt_next;
  logic [WindowW-1:0] hold_cnt, hold_cnt_next;
  logic [LimitW-1:0]  deb_cnt, deb_cnt_next;
  logic               filt, filt_next;
  logic               accept;
  result_t            res, res_next;

  logic [StateW-1:0]  st_cur;
  logic               win_over;
  logic [WindowW-1:0] win_inc;
  logic [LimitW-1:0]  deb_s;
  logic               filt_s;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // integrating debounce, committed only when the state samples the switch
  always_comb begin
    deb_s  = deb_cnt;
    filt_s = filt;
    if (switch_pressed) begin
      if (deb_cnt >= limit) begin
        deb_s  = limit;
        filt_s = 1'b1;
      end else begin
        deb_s = deb_cnt + 1'b1;
      end
    end else begin
      if (deb_cnt == '0) begin
        filt_s = 1'b0;
      end else begin
        deb_s = deb_cnt - 1'b1;
      end
    end
  end

  assign win_over = win_cnt > window;
  assign st_cur   = win_over ? ST_TIMEOUT : state;
  assign win_inc  = win_over ? win_cnt : win_cnt + 1'b1;

  always_comb begin
    state_next    = st_cur;
    win_cnt_next  = win_inc;
    hold_cnt_next = hold_cnt;
    deb_cnt_next  = deb_s;
    filt_next     = filt_s;
    res_next      = '0;
    case (st_cur)
      ST_WAIT_RELEASE: begin
        if (!filt_s) state_next = ST_WAIT_DBL_PUSH;
      end
      ST_WAIT_DBL_PUSH: begin
        if (filt_s) state_next = ST_WAIT_DBL_RELEASE;
      end
      ST_WAIT_DBL_RELEASE: begin
        if (!filt_s) begin
          win_cnt_next  = '0;
          hold_cnt_next = '0;
          state_next    = ST_DBL_HOLDOFF;
          res_next.dbl  = 1'b1;
          res_next.irq  = 1'b1;
        end
      end
      ST_DBL_HOLDOFF: begin
        // switch not sampled here
        deb_cnt_next = deb_cnt;
        filt_next    = filt;
        win_cnt_next = '0;
        if (hold_cnt > window) begin
          state_next = ST_WAIT_PUSH;
        end else begin
          hold_cnt_next = hold_cnt + 1'b1;
        end
      end
      ST_TIMEOUT: begin
        win_cnt_next  = '0;
        res_next.push = 1'b1;
        res_next.irq  = 1'b1;
        if (filt_s) begin
          state_next = ST_PUSH_RESET;
        end else begin
          state_next          = ST_WAIT_PUSH;
          res_next.release_ev = 1'b1;
        end
      end
      ST_PUSH_RESET: begin
        win_cnt_next = '0;
        if (!filt_s) begin
          state_next          = ST_WAIT_PUSH;
          res_next.release_ev = 1'b1;
          res_next.irq        = 1'b1;
        end
      end
      default: begin
        win_cnt_next = '0;
        state_next   = filt_s ? ST_WAIT_RELEASE : ST_WAIT_PUSH;
      end
    endcase
    res_next.filtered = filt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= LimitReset;
      window <= WindowReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegDebounceLimit: limit  <= cfg_data[LimitW-1:0];
        RegDoubleWindow:  window <= cfg_data[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT_PUSH;
      win_cnt   <= '0;
      hold_cnt  <= '0;
      deb_cnt   <= '0;
      filt      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state    <= state_next;
        win_cnt  <= win_cnt_next;
        hold_cnt <= hold_cnt_next;
        deb_cnt  <= deb_cnt_next;
        filt     <= filt_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign filtered_pressed  = res.filtered;
  assign push_event        = res.push;
  assign release_event     = res.release_ev;
  assign double_push_event = res.dbl;
  assign irq_pulse         = res.irq;

`ifndef SYNTHESIS
  a_irq_on_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (push_event || release_event || double_push_event) |-> irq_pulse)
    else $error("event without irq");

  a_no_push_and_dbl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(push_event && double_push_event))
    else $error("push and double push together");

  a_timeout_push: assert property (@(posedge clk) disable iff (rst)
    accept && (state == ST_TIMEOUT || win_cnt > window) |=> push_event)
    else $error("timeout without push event");

  a_holdoff_no_sample: assert property (@(posedge clk) disable iff (rst)
    accept && state == ST_DBL_HOLDOFF && !(win_cnt > window) |=>
      $stable(filt) && $stable(deb_cnt))
    else $error("debounce advanced during hold-off");

  a_dbl_enters_holdoff: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.dbl |=> state == ST_DBL_HOLDOFF && win_cnt == '0)
    else $error("double push did not enter hold-off");
`endif

endmodule
